>>> rtl/core/cms_pkg.sv
// ----------------------------------------------------------------------------
// Counting multiset table package
// Sizes, status codes and the beat types shared by the table and its wrapper.
// ----------------------------------------------------------------------------
package cms_pkg;

  localparam int ENTRIES    = 64;
  localparam int COUNT_BITS = 16;

  localparam int VALUE_W    = 32;
  localparam int ECOUNT_W   = 16;
  localparam int TOTAL_W    = 22;
  localparam int DIST_W     = 7;

  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int USED_W     = $clog2(ENTRIES + 1);
  localparam int ENTRY_W    = VALUE_W + COUNT_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    ST_NEW       = 3'd0,
    ST_INCREMENT = 3'd1,
    ST_DECREMENT = 3'd2,
    ST_DELETED   = 3'd3,
    ST_ABSENT    = 3'd4,
    ST_FULL      = 3'd5,
    ST_SATURATED = 3'd6
  } cms_status_t;

  typedef enum logic {
    FN_INSERT = 1'b0,
    FN_REMOVE = 1'b1
  } cms_func_t;

  typedef struct packed {
    logic                func;
    logic [VALUE_W-1:0]  value;
  } cms_req_t;

  typedef struct packed {
    cms_status_t          status;
    logic [ECOUNT_W-1:0]  element_count;
    logic [TOTAL_W-1:0]   total_size;
    logic [DIST_W-1:0]    distinct_entries;
  } cms_resp_t;

endpackage

>>> rtl/core/cms_table.sv
// ----------------------------------------------------------------------------
// Counting multiset table engine
// Holds the entry memory and a sequencer that searches it one entry per cycle,
// updates the hit entry or appends a new one, and closes the gap after a deletion.
// ----------------------------------------------------------------------------
module cms_table (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  cms_pkg::cms_req_t req,
  output logic              resp_valid,
  input  logic              resp_ready,
  output cms_pkg::cms_resp_t resp
);
  import cms_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_DECIDE = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic                  func_r, func_nxt;
  logic [VALUE_W-1:0]    val_r, val_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  hit_r, hit_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [USED_W-1:0]     used_r, used_nxt;
  logic [TOTAL_W-1:0]    total_r, total_nxt;
  cms_resp_t             res_r, res_nxt;

  logic [ENTRY_W-1:0]    mem [ENTRIES];
  logic [ENTRY_W-1:0]    rd_r;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [ENTRY_W-1:0]    wr_data;

  logic [USED_W:0]       idx_ext;
  logic [VALUE_W-1:0]    rd_value;
  logic [COUNT_BITS-1:0] rd_count;

  assign idx_ext  = (USED_W+1)'(idx_r);
  assign rd_value = rd_r[ENTRY_W-1 -: VALUE_W];
  assign rd_count = rd_r[COUNT_BITS-1:0];

  assign req_ready  = (state_r == S_IDLE);
  assign resp_valid = (state_r == S_DONE);
  assign resp       = res_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    val_nxt   = val_r;
    idx_nxt   = idx_r;
    hit_nxt   = hit_r;
    cnt_nxt   = cnt_r;
    used_nxt  = used_r;
    total_nxt = total_r;
    res_nxt   = res_r;
    rd_addr   = idx_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = rd_r;
    unique case (state_r)
      S_IDLE: begin
        rd_addr = '0;
        if (req_valid) begin
          func_nxt = req.func;
          val_nxt  = req.value;
          idx_nxt  = '0;
          hit_nxt  = 1'b0;
          state_nxt = (used_r == '0) ? S_DECIDE : S_SEARCH;
        end
      end
      S_SEARCH: begin
        rd_addr = IDX_W'(idx_ext + 1'b1);
        if (rd_value == val_r) begin
          hit_nxt   = 1'b1;
          cnt_nxt   = rd_count;
          state_nxt = S_DECIDE;
        end else if (idx_ext + 1'b1 == (USED_W+1)'(used_r)) begin
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt = IDX_W'(idx_ext + 1'b1);
        end
      end
      S_DECIDE: begin
        rd_addr   = IDX_W'(idx_ext + 1'b1);
        state_nxt = S_DONE;
        res_nxt.element_count = '0;
        if (func_r == FN_INSERT) begin
          if (hit_r) begin
            if (cnt_r == COUNT_MAX) begin
              res_nxt.status        = ST_SATURATED;
              res_nxt.element_count = ECOUNT_W'(cnt_r);
            end else begin
              wr_en     = 1'b1;
              wr_addr   = idx_r;
              wr_data   = {val_r, cnt_r + 1'b1};
              total_nxt = total_r + 1'b1;
              res_nxt.status        = ST_INCREMENT;
              res_nxt.element_count = ECOUNT_W'(cnt_r + 1'b1);
            end
          end else if (used_r == USED_W'(ENTRIES)) begin
            res_nxt.status = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = IDX_W'(used_r);
            wr_data   = {val_r, COUNT_BITS'(1)};
            used_nxt  = used_r + 1'b1;
            total_nxt = total_r + 1'b1;
            res_nxt.status        = ST_NEW;
            res_nxt.element_count = ECOUNT_W'(1);
          end
        end else begin
          if (!hit_r) begin
            res_nxt.status = ST_ABSENT;
          end else if (cnt_r > COUNT_BITS'(1)) begin
            wr_en     = 1'b1;
            wr_addr   = idx_r;
            wr_data   = {val_r, cnt_r - 1'b1};
            total_nxt = total_r - TOTAL_W'(total_r != '0);
            res_nxt.status        = ST_DECREMENT;
            res_nxt.element_count = ECOUNT_W'(cnt_r - 1'b1);
          end else if (idx_ext + 1'b1 < (USED_W+1)'(used_r)) begin
            state_nxt = S_SHIFT;
          end else begin
            used_nxt  = used_r - 1'b1;
            total_nxt = total_r - TOTAL_W'(total_r != '0);
            res_nxt.status = ST_DELETED;
          end
        end
        res_nxt.total_size       = total_nxt;
        res_nxt.distinct_entries = DIST_W'(used_nxt);
      end
      S_SHIFT: begin
        rd_addr = IDX_W'(idx_ext + 2'd2);
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_r;
        idx_nxt = IDX_W'(idx_ext + 1'b1);
        if (idx_ext + 2'd2 >= (USED_W+1)'(used_r)) begin
          used_nxt  = used_r - 1'b1;
          total_nxt = total_r - TOTAL_W'(total_r != '0);
          res_nxt.status           = ST_DELETED;
          res_nxt.element_count    = '0;
          res_nxt.total_size       = total_nxt;
          res_nxt.distinct_entries = DIST_W'(used_nxt);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (resp_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    val_r  <= val_nxt;
    idx_r  <= idx_nxt;
    hit_r  <= hit_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(ENTRIES))
    else $error("entry count exceeds table depth");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_DECIDE || state_r == S_SHIFT))
    else $error("memory written outside update or compaction");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (idx_ext + 1'b1 < (USED_W+1)'(used_r)))
    else $error("compaction ran past the last entry");

  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    (resp_valid && resp_ready) |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after the result beat");

  a_used_change: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(used_r) |-> ($past(state_r) == S_DECIDE || $past(state_r) == S_SHIFT))
    else $error("entry count changed outside an update");

endmodule

>>> rtl/core/counting_multiset_table_top.sv
// ----------------------------------------------------------------------------
// Counting multiset table top level
// One beat in flight at a time: the table searches its stored entries in order,
// decides the result and, after a deletion at entry k of N, moves the N-1-k
// entries behind it one place down; up to 64 entries are stored. An output
// stall holds the result. The next input beat is taken once the result has left
// the table, while that result may still wait in the output register.
// Reset empties the table at once; entry contents need no clearing pass.
// ----------------------------------------------------------------------------
module counting_multiset_table_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_func,
  input  logic signed [cms_pkg::VALUE_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_status,
  output logic [cms_pkg::ECOUNT_W-1:0] out_element_count,
  output logic [cms_pkg::TOTAL_W-1:0] out_total_size,
  output logic [cms_pkg::DIST_W-1:0]  out_distinct_entries
);
  import cms_pkg::*;

  cms_req_t  req;
  cms_resp_t resp;
  cms_resp_t out_r;
  logic      resp_valid;
  logic      resp_ready;
  logic      out_valid_r;

  assign req.func  = in_func;
  assign req.value = in_value;

  cms_table u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_valid),
    .req_ready  (in_ready),
    .req        (req),
    .resp_valid (resp_valid),
    .resp_ready (resp_ready),
    .resp       (resp)
  );

  assign resp_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_ready) begin
      out_valid_r <= resp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_valid && resp_ready) begin
      out_r <= resp;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_r.status;
  assign out_element_count    = out_r.element_count;
  assign out_total_size       = out_r.total_size;
  assign out_distinct_entries = out_r.distinct_entries;

endmodule
